[hw/rtl/rtufr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtufr_pkg
// shared types, codes and the crc-16 table for the rtu frame receiver
// ----------------------------------------------------------------------------
package rtufr_pkg;

    // largest frame held before further bytes are dropped
    localparam int unsigned MAX_FRAME_BYTES = 256;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned CFG_A_W = 2;

    localparam logic [TICK_W-1:0] CHAR_GAP_RESET  = 16'd1719;
    localparam logic [TICK_W-1:0] FRAME_END_RESET = 16'd4010;
    localparam logic [TICK_W-1:0] IDLE_SYNC_RESET = 16'd4010;
    localparam logic [TICK_W-1:0] SILENCE_MAX     = 16'hFFFF;
    localparam logic [15:0]       CRC_INIT        = 16'hFFFF;
    localparam logic [15:0]       CRC_POLY        = 16'hA001;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_CHAR_GAP  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_FRAME_END = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_IDLE_SYNC = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_READY  = 2'd1,
        MODE_RECV   = 2'd2,
        MODE_ENDGAP = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_BYTE    = 3'd1,
        ST_GOOD    = 3'd2,
        ST_CRC_BAD = 3'd3,
        ST_SHORT   = 3'd4,
        ST_GAP     = 3'd5,
        ST_LONG    = 3'd6
    } t_status;

    // one entry of the reflected crc-16 (0xa001) byte table
    function automatic logic [15:0] crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/rtufr_crc16_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtufr_crc16_update
// one byte step of the modbus crc-16, table form
// ----------------------------------------------------------------------------
module rtufr_crc16_update (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);

    logic [7:0] idx;

    assign idx   = i_crc[7:0] ^ i_byte;
    assign o_crc = (i_crc >> 8) ^ rtufr_pkg::crc_table(idx);

endmodule
`default_nettype wire

[hw/rtl/rtu_frame_receiver_crc_check_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtu_frame_receiver_crc_check_unit
// modbus rtu frame receiver: silence timing, framing and crc-16 verdict
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one word per received byte or time tick: tuser[0] = 1 marks
//   a tick, else tdata[7:0] is the received byte. every accepted word yields
//   exactly one result word on m_axis: tuser holds the status code, tdata the
//   byte, the frame length and the receiver mode after that word.
//   the cfg channel writes the three silence thresholds (index 0 char gap,
//   1 frame end, 2 idle sync); it is always ready and must be used only
//   while no word is in flight.
// pipeline:
//   each word passes the input register, then the result register. one word
//   per cycle sustained while m_axis_tready stays high; the state update with
//   its crc table step and threshold compare sits between the two registers.
// reset:
//   synchronous, active low. the receiver starts in idle wait with zero
//   silence, thresholds back to their defaults, both stages empty.
// stall:
//   when m_axis_tready is low the result holds; the input register still
//   takes one word, after which s_axis_tready drops until the result moves.
// ----------------------------------------------------------------------------
module rtu_frame_receiver_crc_check_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind (1 = tick)
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [7:0] data_byte, [16:8] frame_length,
                                             // [18:17] receiver_mode, [23:19] zero
    output logic      [2:0]  m_axis_tuser,   // [2:0] status
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned TW = rtufr_pkg::TICK_W;
    localparam int unsigned LW = rtufr_pkg::LEN_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(rtufr_pkg::MAX_FRAME_BYTES);

    // ---------------- configuration registers ----------------
    logic [TW-1:0] r_char_gap, r_frame_end, r_idle_sync;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_gap  <= rtufr_pkg::CHAR_GAP_RESET;
            r_frame_end <= rtufr_pkg::FRAME_END_RESET;
            r_idle_sync <= rtufr_pkg::IDLE_SYNC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                rtufr_pkg::REG_CHAR_GAP:  r_char_gap  <= i_cfg_data;
                rtufr_pkg::REG_FRAME_END: r_frame_end <= i_cfg_data;
                rtufr_pkg::REG_IDLE_SYNC: r_idle_sync <= i_cfg_data;
                default: ;  // unused index, ignored
            endcase
        end
    end

    // ---------------- handshake and stage control ----------------
    logic r_in_valid;
    logic r_in_kind;
    logic [7:0] r_in_byte;
    logic r_out_valid;
    logic advance;      // result register can load this cycle
    logic take;         // input register word moves to the result register

    assign advance       = !r_out_valid || m_axis_tready;
    assign take          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_kind <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
    end

    // ---------------- receiver state ----------------
    rtufr_pkg::t_mode r_mode, n_mode;
    logic [TW-1:0]    r_silence, n_silence;
    logic [LW-1:0]    r_byte_count, n_byte_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_last0, n_last0;   // earlier of the two held bytes
    logic [7:0]       r_last1, n_last1;   // most recent byte
    logic             r_overflow, n_overflow;

    // result fields
    rtufr_pkg::t_status r_out_status, n_out_status;
    logic [7:0]         r_out_data, n_out_data;
    logic [LW-1:0]      r_out_len, n_out_len;
    rtufr_pkg::t_mode   r_out_mode;

    logic [15:0] crc_step;
    logic        is_tick;
    logic        frame_full;
    logic        crc_match;

    // crc advances over the byte leaving the two-byte window
    rtufr_crc16_update u_crc (
        .i_crc  (r_crc),
        .i_byte (r_last0),
        .o_crc  (crc_step)
    );

    assign is_tick    = r_in_kind;
    assign frame_full = (r_byte_count >= MAX_LEN);
    // trailing crc arrives low byte first
    assign crc_match  = ({r_last1, r_last0} == r_crc);

    always_comb begin
        n_mode       = r_mode;
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_last0      = r_last0;
        n_last1      = r_last1;
        n_overflow   = r_overflow;
        n_out_status = rtufr_pkg::ST_NONE;
        n_out_data   = 8'h00;
        n_out_len    = r_byte_count;

        // silence counter: a byte clears it, a tick counts up and saturates
        if (is_tick) begin
            n_silence = (r_silence == rtufr_pkg::SILENCE_MAX) ?
                        r_silence : r_silence + TW'(1);
        end else begin
            n_silence = '0;
        end

        case (r_mode)
            rtufr_pkg::MODE_IDLE: begin
                if (is_tick && (n_silence >= r_idle_sync)) begin
                    n_mode = rtufr_pkg::MODE_READY;
                end
            end
            rtufr_pkg::MODE_READY: begin
                if (!is_tick) begin
                    // fresh frame, this byte is its first
                    n_byte_count = LW'(1);
                    n_crc        = rtufr_pkg::CRC_INIT;
                    n_last0      = 8'h00;
                    n_last1      = r_in_byte;
                    n_overflow   = 1'b0;
                    n_mode       = rtufr_pkg::MODE_RECV;
                    n_out_status = rtufr_pkg::ST_BYTE;
                    n_out_data   = r_in_byte;
                    n_out_len    = LW'(1);
                end
            end
            rtufr_pkg::MODE_RECV: begin
                if (!is_tick) begin
                    if (frame_full) begin
                        // byte dropped, frame will be judged too long
                        n_overflow = 1'b1;
                    end else begin
                        if (r_byte_count >= LW'(2)) begin
                            n_crc = crc_step;
                        end
                        n_last0      = r_last1;
                        n_last1      = r_in_byte;
                        n_byte_count = r_byte_count + LW'(1);
                        n_out_status = rtufr_pkg::ST_BYTE;
                        n_out_data   = r_in_byte;
                        n_out_len    = r_byte_count + LW'(1);
                    end
                end else if (n_silence >= r_char_gap) begin
                    n_mode = rtufr_pkg::MODE_ENDGAP;
                end
            end
            rtufr_pkg::MODE_ENDGAP: begin
                if (!is_tick) begin
                    // byte inside the end gap: abandon the frame
                    n_out_status = rtufr_pkg::ST_GAP;
                    n_byte_count = '0;
                    n_crc        = rtufr_pkg::CRC_INIT;
                    n_last0      = 8'h00;
                    n_last1      = 8'h00;
                    n_overflow   = 1'b0;
                    n_mode       = rtufr_pkg::MODE_IDLE;
                end else if (n_silence >= r_frame_end) begin
                    if (r_overflow) begin
                        n_out_status = rtufr_pkg::ST_LONG;
                    end else if (r_byte_count <= LW'(2)) begin
                        n_out_status = rtufr_pkg::ST_SHORT;
                    end else if (crc_match) begin
                        n_out_status = rtufr_pkg::ST_GOOD;
                    end else begin
                        n_out_status = rtufr_pkg::ST_CRC_BAD;
                    end
                    n_byte_count = '0;
                    n_crc        = rtufr_pkg::CRC_INIT;
                    n_last0      = 8'h00;
                    n_last1      = 8'h00;
                    n_overflow   = 1'b0;
                    n_mode       = rtufr_pkg::MODE_READY;
                end
            end
            default: begin
                n_mode = rtufr_pkg::MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= rtufr_pkg::MODE_IDLE;
            r_silence    <= '0;
            r_byte_count <= '0;
            r_crc        <= rtufr_pkg::CRC_INIT;
            r_last0      <= 8'h00;
            r_last1      <= 8'h00;
            r_overflow   <= 1'b0;
        end else if (take) begin
            r_mode       <= n_mode;
            r_silence    <= n_silence;
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_last0      <= n_last0;
            r_last1      <= n_last1;
            r_overflow   <= n_overflow;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_len    <= n_out_len;
            r_out_mode   <= n_mode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {5'b00000, r_out_mode, r_out_len, r_out_data};

    // ---------------- assertions ----------------
    // held frame never grows past the limit
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MAX_LEN)
        else $error("frame length beyond limit");

    // outside a frame nothing is held
    a_no_frame_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == rtufr_pkg::MODE_IDLE || r_mode == rtufr_pkg::MODE_READY)
        |-> (r_byte_count == '0 && !r_overflow))
        else $error("frame state left over outside a frame");

    // a byte result always leaves the receiver in receiving mode
    a_byte_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == rtufr_pkg::ST_BYTE)
        |-> (r_out_mode == rtufr_pkg::MODE_RECV && r_out_len != '0))
        else $error("byte result outside receiving mode");

    // input only stalls when both stages are full and the sink is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without back pressure");

endmodule
`default_nettype wire
